// File: rtl/barometric_sensor_compensation_defines.svh
// Assertion macros for the barometric sensor compensation block.
`ifndef BAROMETRIC_SENSOR_COMPENSATION_DEFINES_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_DEFINES_SVH

// Clocked property, switched off while in reset.
`define BSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds through reset.
`define BSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bsc_pkg.sv
// Shared types, constants and helpers for the barometric compensation block.
package bsc_pkg;

  localparam int DIV_W = 32;
  // register stages from a start transfer to the result strobe
  localparam int LATENCY = 17 + 2 * DIV_W;

  typedef enum logic [2:0] {
    REG_A1     = 3'd0,
    REG_A2     = 3'd1,
    REG_A3     = 3'd2,
    REG_A4     = 3'd3,
    REG_A5_A6  = 3'd4,
    REG_B1     = 3'd5,
    REG_B2     = 3'd6,
    REG_MC_MD  = 3'd7
  } reg_index_t;

  // per-item payload carried down the pipe; a..d are working words
  typedef struct packed {
    logic [18:0] up;
    logic [15:0] temp;
    logic        fault;
    logic        flag;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } item_t;

  localparam logic [31:0] K_B6_OFS = 32'd4000;
  localparam logic [31:0] K_HALF   = 32'd32768;
  localparam logic [31:0] K_P1     = 32'd3038;
  localparam logic [31:0] K_P2     = 32'hFFFF_E343; // -7357
  localparam logic [31:0] K_P3     = 32'd3791;

  function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned s);
    return 32'($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

// File: rtl/barometric_sensor_compensation.sv
// Top level: barometric sensor compensation pipeline with coefficient registers.
// Usage
// - Coefficients are loaded through wr_en / wr_index / wr_data, one register per
//   write, no wait states, no read-back. Load them only while the pipe is empty.
// - An item transfer happens on a rising edge with start high and busy low. busy
//   is always low: a new item may enter every cycle.
// - Each result appears for one cycle with done high; throughput is one item per cycle.
// - Latency is set by the two 32-stage divider pipes (temperature quotient and
//   pressure quotient) plus 17 stages of multiply, shift and add.
// - The receiver cannot stall; results are simply shown on done.
// - A zero divisor raises divide_fault and forces both results to zero.
// - Synchronous reset clears all valid bits and all coefficients; items in
//   flight are dropped.
module barometric_sensor_compensation import bsc_pkg::*; #(
  parameter int OVERSAMPLING = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        raw_temperature,
  input  logic [18:0]        raw_pressure,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [31:0]        wr_data,
  output logic               done,
  output logic signed [15:0] temperature_tenths,
  output logic signed [31:0] pressure_pa,
  output logic               divide_fault
);

  localparam int          OSS   = OVERSAMPLING % 4;
  localparam logic [31:0] K_B7  = 32'(50000 >> OSS);
  localparam int          SIDE_W = $bits(item_t);

  // calibration registers
  logic [15:0] coef_a1, coef_a2, coef_a3, coef_a4, coef_b1, coef_b2;
  logic [31:0] coef_a5_a6, coef_mc_md;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a1 <= '0; coef_a2 <= '0; coef_a3 <= '0; coef_a4 <= '0;
      coef_b1 <= '0; coef_b2 <= '0; coef_a5_a6 <= '0; coef_mc_md <= '0;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_A1:    coef_a1    <= wr_data[15:0];
        REG_A2:    coef_a2    <= wr_data[15:0];
        REG_A3:    coef_a3    <= wr_data[15:0];
        REG_A4:    coef_a4    <= wr_data[15:0];
        REG_A5_A6: coef_a5_a6 <= wr_data;
        REG_B1:    coef_b1    <= wr_data[15:0];
        REG_B2:    coef_b2    <= wr_data[15:0];
        REG_MC_MD: coef_mc_md <= wr_data;
        default:   ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx16(coef_a1);
  assign ac2 = sx16(coef_a2);
  assign ac3 = sx16(coef_a3);
  assign ac4 = {16'd0, coef_a4};
  assign ac5 = {16'd0, coef_a5_a6[31:16]};
  assign ac6 = {16'd0, coef_a5_a6[15:0]};
  assign b1  = sx16(coef_b1);
  assign b2  = sx16(coef_b2);
  assign mc  = sx16(coef_mc_md[31:16]);
  assign md  = sx16(coef_mc_md[15:0]);

  assign busy = 1'b0;

  // front: s0 capture, s1 (UT-AC6)*AC5, s2 X1, |num|, |den|
  item_t s0, s1, s2, s0_next, s1_next, s2_next;
  logic  v0, v1, v2;

  always_comb begin
    s0_next    = '0;
    s0_next.a  = {16'd0, raw_temperature};
    s0_next.up = raw_pressure;
    s1_next    = s0;
    s1_next.a  = (s0.a - ac6) * ac5;
  end

  always_comb begin
    logic [31:0] x1, den, num;
    s2_next       = s1;
    x1            = asr(s1.a, 15);
    den           = x1 + md;
    num           = mc << 11;
    s2_next.b     = x1;
    s2_next.c     = num[31] ? 32'(-num) : num;
    s2_next.d     = den[31] ? 32'(-den) : den;
    s2_next.flag  = num[31] ^ den[31];
    s2_next.fault = (den == 32'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0;
    end else begin
      v0 <= start & ~busy; v1 <= v0; v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    s0 <= s0_next;
    s1 <= s1_next;
    s2 <= s2_next;
  end

  // temperature quotient (MC << 11) / (X1 + MD)
  item_t       d1_side;
  logic [31:0] d1_quo;
  logic        d1_valid;

  bsc_div_pipe #(.W(DIV_W), .SIDE_W(SIDE_W)) u_div_t (
    .clk, .rst,
    .in_valid (v2),
    .num      (s2.c),
    .den      (s2.d),
    .in_side  (s2),
    .out_valid(d1_valid),
    .quo      (d1_quo),
    .out_side (d1_side)
  );

  // middle: s3..s12, B5 through B7 and B4
  item_t s3, s4, s5, s6, s7, s8, s9, s10, s11, s12;
  item_t s3_next, s4_next, s5_next, s6_next, s7_next;
  item_t s8_next, s9_next, s10_next, s11_next, s12_next;
  logic  v3, v4, v5, v6, v7, v8, v9, v10, v11, v12;
  logic [31:0] b4_w;
  assign b4_w = s10.b >> 15;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v3, v4, v5, v6, v7, v8, v9, v10, v11, v12} <= '0;
    end else begin
      {v3, v4, v5, v6, v7, v8, v9, v10, v11, v12} <=
        {d1_valid, v3, v4, v5, v6, v7, v8, v9, v10, v11};
    end
  end

  always_comb begin
    logic [31:0] tq;
    // B5 = X1 + X2
    s3_next      = d1_side;
    s3_next.a    = d1_side.b + (d1_side.flag ? 32'(-d1_quo) : d1_quo);
    // temperature, B6
    tq           = asr(s3.a + 32'd8, 4);
    s4_next      = s3;
    s4_next.temp = tq[15:0];
    s4_next.a    = s3.a - K_B6_OFS;
    // B6 products
    s5_next      = s4;
    s5_next.b    = s4.a * s4.a;
    s5_next.c    = ac2 * s4.a;
    s5_next.d    = ac3 * s4.a;
    s6_next      = s5;
    s6_next.b    = asr(s5.b, 12);
    s6_next.c    = asr(s5.c, 11);
    s6_next.d    = asr(s5.d, 13);
    s7_next      = s6;
    s7_next.a    = b2 * s6.b;
    s7_next.b    = b1 * s6.b;
    s8_next      = s7;
    s8_next.a    = asr(s7.a, 11) + s7.c;
    s8_next.b    = s7.d + asr(s7.b, 16) + 32'd2;
    // B3 and X3 + 32768
    s9_next      = s8;
    s9_next.a    = asr((((ac1 << 2) + s8.a) << OSS) + 32'd2, 2);
    s9_next.b    = asr(s8.b, 2) + K_HALF;
    s10_next     = s9;
    s10_next.b   = ac4 * s9.b;
    s10_next.a   = {13'd0, s9.up} - s9.a;
    // B4, B7
    s11_next       = s10;
    s11_next.b     = b4_w;
    s11_next.fault = s10.fault | (b4_w == 32'd0);
    s11_next.a     = s10.a * K_B7;
    s12_next       = s11;
    s12_next.flag  = s11.a[31];
    s12_next.a     = s11.a[31] ? s11.a : (s11.a << 1);
  end

  always_ff @(posedge clk) begin
    s3  <= s3_next;
    s4  <= s4_next;
    s5  <= s5_next;
    s6  <= s6_next;
    s7  <= s7_next;
    s8  <= s8_next;
    s9  <= s9_next;
    s10 <= s10_next;
    s11 <= s11_next;
    s12 <= s12_next;
  end

  // pressure quotient
  item_t       d2_side;
  logic [31:0] d2_quo;
  logic        d2_valid;

  bsc_div_pipe #(.W(DIV_W), .SIDE_W(SIDE_W)) u_div_p (
    .clk, .rst,
    .in_valid (v12),
    .num      (s12.a),
    .den      (s12.b),
    .in_side  (s12),
    .out_valid(d2_valid),
    .quo      (d2_quo),
    .out_side (d2_side)
  );

  // back: p correction terms
  item_t s13, s14, s15, s13_next, s14_next, s15_next;
  logic  v13, v14, v15;
  logic [31:0] p8, x1_f, p_f;
  assign p8   = asr(s13.a, 8);
  assign x1_f = asr(s15.b, 16);
  assign p_f  = s15.a + asr(x1_f + s15.c + K_P3, 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v13 <= 1'b0; v14 <= 1'b0; v15 <= 1'b0; done <= 1'b0;
    end else begin
      v13 <= d2_valid; v14 <= v13; v15 <= v14; done <= v15;
    end
  end

  always_comb begin
    s13_next   = d2_side;
    s13_next.a = d2_side.flag ? (d2_quo << 1) : d2_quo;
    s14_next   = s13;
    s14_next.b = p8 * p8;
    s14_next.c = K_P2 * s13.a;
    s15_next   = s14;
    s15_next.b = s14.b * K_P1;
    s15_next.c = asr(s14.c, 16);
  end

  always_ff @(posedge clk) begin
    s13 <= s13_next;
    s14 <= s14_next;
    s15 <= s15_next;
    temperature_tenths <= s15.fault ? 16'sd0 : $signed(s15.temp);
    pressure_pa        <= s15.fault ? 32'sd0 : $signed(p_f);
    divide_fault       <= s15.fault;
  end

endmodule

// File: rtl/bsc_div_pipe.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
module bsc_div_pipe import bsc_pkg::*; #(
  parameter int W      = 32,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [W-1:0]      num,
  input  logic [W-1:0]      den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [W-1:0]      quo,
  output logic [SIDE_W-1:0] out_side
);

  logic [W-1:0]      rem_q [W];
  logic [W-1:0]      quo_q [W];
  logic [W-1:0]      den_q [W];
  logic [SIDE_W-1:0] side_q [W];
  logic              vld_q [W];

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W-1:0]      r_in, q_in, d_in;
    logic [SIDE_W-1:0] s_in;
    logic              v_in;
    logic [W:0]        trial;

    if (i == 0) begin : g_first
      assign r_in = '0;
      assign q_in = num;
      assign d_in = den;
      assign s_in = in_side;
      assign v_in = in_valid;
    end else begin : g_next
      assign r_in = rem_q[i-1];
      assign q_in = quo_q[i-1];
      assign d_in = den_q[i-1];
      assign s_in = side_q[i-1];
      assign v_in = vld_q[i-1];
    end

    assign trial = {r_in, q_in[W-1]} - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[i]  <= trial[W] ? {r_in[W-2:0], q_in[W-1]} : trial[W-1:0];
      quo_q[i]  <= {q_in[W-2:0], ~trial[W]};
      den_q[i]  <= d_in;
      side_q[i] <= s_in;
    end
  end

  assign out_valid = vld_q[W-1];
  assign quo       = quo_q[W-1];
  assign out_side  = side_q[W-1];

endmodule

// File: rtl/bsc_checker.sv
// Port-level checker for the compensation block, bound to the top level.
`include "barometric_sensor_compensation_defines.svh"

module bsc_checker import bsc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [15:0] temperature_tenths,
  input logic signed [31:0] pressure_pa,
  input logic               divide_fault
);

  `BSC_ASSERT_ALWAYS(a_never_busy, (!busy), "busy raised")
  `BSC_ASSERT(a_fault_zero,
    (done && divide_fault |-> temperature_tenths == 16'sd0 && pressure_pa == 32'sd0),
    "fault result not zero")
  `BSC_ASSERT(a_latency, (done |-> $past(start && !busy, LATENCY)), "result without transfer")
  `BSC_ASSERT_ALWAYS(a_reset_quiet, ($past(rst) |-> !done), "result after reset")

endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (.*);
